>>> rtl/core/clmf_pkg.sv
// Package for the clipped box mean filter.
// Holds the window sum and count widths and the per-channel sum type.
// Used by clmf_div and clipped_box_mean_filter; no dependencies.
`default_nettype none
package clmf_pkg;
	// A 5x5 window of 8-bit values sums to at most 6375.
	localparam int SUM_W = 13;
	// The clipped window holds 9 to 25 pixels.
	localparam int CNT_W = 5;
	localparam int NUM_CH = 3;

	typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_arr_t;
endpackage
`default_nettype wire

>>> rtl/core/clmf_div.sv
// Restoring divider for the three channel sums of one window.
// One quotient bit per cycle for all three channels; depends on clmf_pkg.
`default_nettype none
module clmf_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire clmf_pkg::sum_arr_t        sums,
	input  wire logic [clmf_pkg::CNT_W-1:0] divisor,
	output logic                           done,
	output clmf_pkg::sum_arr_t             quot
);
	import clmf_pkg::*;

	localparam int IT_W = $clog2(SUM_W + 1);

	logic [IT_W-1:0]  iter_q;
	logic             done_q;
	logic [CNT_W-1:0] div_q;
	sum_arr_t         quot_q;
	logic [NUM_CH-1:0][CNT_W-1:0] rem_q;

	// Control: iteration counter and a done pulse after the last bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				iter_q <= IT_W'(SUM_W);
			end else if (iter_q != '0) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == IT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift in one dividend bit and subtract where it fits.
	always_ff @(posedge clk) begin
		logic [CNT_W:0] trial;
		if (start) begin
			quot_q <= sums;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (iter_q != '0) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				trial = {rem_q[ch], quot_q[ch][SUM_W-1]};
				if (trial >= {1'b0, div_q}) begin
					rem_q[ch]  <= CNT_W'(trial - {1'b0, div_q});
					quot_q[ch] <= {quot_q[ch][SUM_W-2:0], 1'b1};
				end else begin
					rem_q[ch]  <= trial[CNT_W-1:0];
					quot_q[ch] <= {quot_q[ch][SUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

>>> rtl/core/clipped_box_mean_filter.sv
// Clipped 5x5 box mean filter over a raster stream of three-channel pixels.
// An item that frees no result passes only through the accept and check states.
// One that frees a result passes a check, the 5x5 window reads from the single-port line store,
// a final accumulate step, a divider start, the divider steps, a wait for the divider to finish
// and the output load (stalls while full); the next item is taken in the cycle after the load.
// Reset clears counters and the output valid and sets the configuration to its defaults; the line store is not cleared.
`default_nettype none
module clipped_box_mean_filter #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  first_channel,
	input  wire logic [7:0]  second_channel,
	input  wire logic [7:0]  third_channel,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       mean_first,
	output logic [7:0]       mean_second,
	output logic [7:0]       mean_third,
	output logic             last_of_frame
);
	import clmf_pkg::*;

	localparam int RING = 6;
	localparam int DEPTH = RING * MAX_WIDTH;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int CLW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(2 * MAX_WIDTH + 4);
	localparam int RW = 12;
	localparam int HW = 13;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_COLOR = 2'd2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_LAST = 3'd3;
	localparam logic [2:0] ST_START = 3'd4;
	localparam logic [2:0] ST_DIV = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	logic [2:0]     state_q;
	logic [11:0]    width_q;
	logic [12:0]    height_q;
	logic           color_q;
	logic [CLW-1:0] in_col_q, out_col_q;
	logic [RW-1:0]  in_row_q, out_row_q;
	logic [2:0]     in_slot_q, out_slot_q;
	logic [PW-1:0]  pending_q;
	logic [2:0]     di_q, ei_q;
	logic           last_q;

	logic [23:0]    mem [DEPTH];
	logic [23:0]    rd_data_s1;
	logic           vld_s1;

	sum_arr_t       acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic           div_start, div_done;
	sum_arr_t       quot;

	logic [7:0]     mf_q, ms_q, mt_q;
	logic           lof_q, ovld_q;

	// Effective frame size, clamped into range.
	logic [CW-1:0]  eff_w;
	logic [HW-1:0]  eff_h;
	always_comb begin
		if (width_q < 12'd5) begin
			eff_w = CW'(5);
		end else if ({{(CW + 1){1'b0}}, width_q} > (CW + 13)'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(width_q);
		end
		if (height_q < 13'd5) begin
			eff_h = HW'(5);
		end else if (height_q > 13'd4096) begin
			eff_h = HW'(4096);
		end else begin
			eff_h = height_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);

	logic in_acc, pix_wr, out_take;
	assign in_acc = in_valid && in_ready;
	assign pix_wr = in_acc && !kind;
	assign out_take = ovld_q && out_ready;

	// Distance from the next result to the last pixel its window needs.
	logic [1:0]    dr, dc;
	logic [PW-1:0] need;
	logic [HW-1:0] h_left;
	logic [CW-1:0] w_left;
	always_comb begin
		h_left = eff_h - 1'b1 - HW'(out_row_q);
		w_left = eff_w - 1'b1 - CW'(out_col_q);
		dr = (h_left >= HW'(2)) ? 2'd2 : h_left[1:0];
		dc = (w_left >= CW'(2)) ? 2'd2 : w_left[1:0];
		unique case (dr)
			2'd2:    need = PW'({eff_w, 1'b0});
			2'd1:    need = PW'(eff_w);
			default: need = '0;
		endcase
		need = need + PW'(dc);
	end

	// Window position of the current read and whether it lies in the frame.
	logic [HW:0]   rr_sum;
	logic [CW+1:0] cc_sum;
	logic          pos_ok;
	logic [3:0]    slot_sum;
	logic [2:0]    rd_slot;
	logic [CLW-1:0] rd_col;
	logic [AW-1:0] rd_addr, wr_addr;
	always_comb begin
		rr_sum = (HW + 1)'(out_row_q) + (HW + 1)'(di_q);
		cc_sum = (CW + 2)'(out_col_q) + (CW + 2)'(ei_q);
		pos_ok = (rr_sum >= (HW + 1)'(2)) && (rr_sum < (HW + 1)'(eff_h) + (HW + 1)'(2))
			&& (cc_sum >= (CW + 2)'(2)) && (cc_sum < (CW + 2)'(eff_w) + (CW + 2)'(2));
		slot_sum = 4'(out_slot_q) + 4'(di_q) + 4'd4;
		if (slot_sum >= 4'd12) begin
			rd_slot = 3'(slot_sum - 4'd12);
		end else if (slot_sum >= 4'd6) begin
			rd_slot = 3'(slot_sum - 4'd6);
		end else begin
			rd_slot = slot_sum[2:0];
		end
		rd_col = CLW'(cc_sum - (CW + 2)'(2));
		rd_addr = AW'(rd_slot * MAX_WIDTH) + AW'(rd_col);
		wr_addr = AW'(in_slot_q * MAX_WIDTH) + AW'(in_col_q);
	end

	// Line store: one port, writes on pixel items, reads during the window sweep.
	always_ff @(posedge clk) begin
		if (pix_wr) begin
			mem[wr_addr] <= {third_channel, second_channel, first_channel};
		end else if (state_q == ST_READ) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Accumulate the channel sums and the pixel count of the clipped window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_READ) && pos_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (vld_s1) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				acc_q[ch] <= acc_q[ch] + SUM_W'(rd_data_s1[ch*8 +: 8]);
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign div_start = (state_q == ST_START);

	clmf_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.sums    (acc_q),
		.divisor (cnt_q),
		.done    (div_done),
		.quot    (quot)
	);

	// Sequencer, stream counters and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			width_q    <= 12'd640;
			height_q   <= 13'd480;
			color_q    <= 1'b1;
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pending_q  <= '0;
			di_q       <= '0;
			ei_q       <= '0;
			last_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q <= cfg_data[11:0];
					REG_HEIGHT: height_q <= cfg_data;
					REG_COLOR:  color_q <= cfg_data[0];
					default:    ;
				endcase
				if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_slot_q  <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_slot_q <= '0;
					pending_q  <= '0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_CHECK;
						if (!kind) begin
							pending_q <= pending_q + 1'b1;
							if (CW'(in_col_q) + 1'b1 >= eff_w) begin
								in_col_q  <= '0;
								in_slot_q <= (in_slot_q == 3'(RING - 1)) ? 3'd0
									: in_slot_q + 1'b1;
								in_row_q  <= (HW'(in_row_q) + 1'b1 >= eff_h) ? '0
									: in_row_q + 1'b1;
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
					end
				end
				ST_CHECK: begin
					di_q   <= '0;
					ei_q   <= '0;
					last_q <= (HW'(out_row_q) == eff_h - 1'b1)
						&& (CW'(out_col_q) == eff_w - 1'b1);
					state_q <= (pending_q > need) ? ST_READ : ST_IDLE;
				end
				ST_READ: begin
					if (ei_q == 3'd4) begin
						ei_q <= '0;
						if (di_q == 3'd4) begin
							state_q <= ST_LAST;
						end else begin
							di_q <= di_q + 1'b1;
						end
					end else begin
						ei_q <= ei_q + 1'b1;
					end
				end
				ST_LAST: begin
					// Window is read: move on to the next result position.
					pending_q <= pending_q - 1'b1;
					if (CW'(out_col_q) + 1'b1 >= eff_w) begin
						out_col_q  <= '0;
						out_slot_q <= (out_slot_q == 3'(RING - 1)) ? 3'd0
							: out_slot_q + 1'b1;
						out_row_q  <= (HW'(out_row_q) + 1'b1 >= eff_h) ? '0
							: out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
					state_q <= ST_START;
				end
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!ovld_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: loaded once the previous item has been taken.
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!ovld_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (out_load) begin
			ovld_q <= 1'b1;
		end else if (out_take) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mf_q  <= quot[0][7:0];
			ms_q  <= color_q ? quot[1][7:0] : 8'd0;
			mt_q  <= color_q ? quot[2][7:0] : 8'd0;
			lof_q <= last_q;
		end
	end

	assign out_valid = ovld_q;
	assign mean_first = mf_q;
	assign mean_second = ms_q;
	assign mean_third = mt_q;
	assign last_of_frame = lof_q;

`ifndef SYNTHESIS
	// The divider finishes only while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside of the divide state");

	// A clipped 5x5 window always holds 9 to 25 pixels.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_START |-> (cnt_q >= CNT_W'(9) && cnt_q <= CNT_W'(25)))
		else $error("window pixel count out of range");

	// Pixel writes never collide with the window sweep.
	a_no_wr_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		pix_wr |-> state_q == ST_IDLE && !vld_s1)
		else $error("line store write during window read");
`endif
endmodule
`default_nettype wire
